>>> design/srtrb_pkg.sv
// Package: command codes and shared types for the serial ring buffer block.
`timescale 1ns / 1ps

package srtrb_pkg;

    localparam logic [2:0] KIND_HOST_WRITE = 3'd0;
    localparam logic [2:0] KIND_HOST_READ  = 3'd1;
    localparam logic [2:0] KIND_LINK_BYTE  = 3'd2;
    localparam logic [2:0] KIND_TX_TICK    = 3'd3;
    localparam logic [2:0] KIND_RX_FLUSH   = 3'd4;

    localparam int FREE_W = 6;

    // Flags carried from the accept stage to the result register.
    typedef struct packed {
        logic              read_valid;
        logic              tx_valid;
        logic              accepted;
        logic              driver_on;
        logic [FREE_W-1:0] rx_free;
    } stage_t;

endpackage

>>> design/srtrb_in_if.sv
// Interface: command channel into the ring buffer block.
`timescale 1ns / 1ps

interface srtrb_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] data;
    logic       link_ready;

    modport source (output valid, output kind, output data, output link_ready, input ready);
    modport sink   (input valid, input kind, input data, input link_ready, output ready);
endinterface

>>> design/srtrb_out_if.sv
// Interface: response channel out of the ring buffer block.
`timescale 1ns / 1ps

interface srtrb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       read_valid;
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       accepted;
    logic       driver_on;
    logic [5:0] rx_free;

    modport source (output valid, output read_data, output read_valid, output tx_byte,
                    output tx_valid, output accepted, output driver_on, output rx_free,
                    input ready);
    modport sink   (input valid, input read_data, input read_valid, input tx_byte,
                    input tx_valid, input accepted, input driver_on, input rx_free,
                    output ready);
endinterface

>>> design/serial_rx_tx_ring_buffers.sv
// Top level: transmit and receive byte rings between a host and a serial link.
//
//  channel | dir | payload                                           | transaction when
//  --------+-----+---------------------------------------------------+-------------------
//  cmd     | in  | kind, data, link_ready                            | valid && ready
//  rsp     | out | read_data, read_valid, tx_byte, tx_valid,         | valid && ready
//          |     | accepted, driver_on, rx_free                      |
//
// One command a cycle is taken while cmd.ready is high; each passes through the stage
// register, in step with the registered RAM read port, and then the result register.
// Reset clears both rings' pointers and the driver enable; no clearing pass is run,
// as RAM read data is only used after the slot has been written.
// A stalled response holds in the result register; the RAM read data and the stage
// flags hold behind it, and cmd.ready drops only while both are full and rsp stalls.
`timescale 1ns / 1ps

module serial_rx_tx_ring_buffers
    import srtrb_pkg::*;
#(
    parameter int unsigned RX_DEPTH = 64,
    parameter int unsigned TX_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    srtrb_in_if.sink    cmd,
    srtrb_out_if.source rsp
);

    localparam int RX_PW = $clog2(RX_DEPTH);
    localparam int TX_PW = $clog2(TX_DEPTH);
    // Width wide enough for the fill arithmetic and for the 6-bit report.
    localparam int CW    = (RX_PW + 1 > FREE_W) ? RX_PW + 1 : FREE_W;
    localparam logic [CW-1:0]    RX_DEPTH_C = CW'(RX_DEPTH);
    localparam logic [RX_PW-1:0] RX_LAST    = RX_PW'(RX_DEPTH - 1);
    localparam logic [TX_PW-1:0] TX_LAST    = TX_PW'(TX_DEPTH - 1);

    // Ring pointers and driver enable
    logic [TX_PW-1:0] tx_wp_reg, tx_wp_next;
    logic [TX_PW-1:0] tx_rp_reg, tx_rp_next;
    logic [RX_PW-1:0] rx_wp_reg, rx_wp_next;
    logic [RX_PW-1:0] rx_rp_reg, rx_rp_next;
    logic             driver_reg, driver_next;

    // Stage between accept and result register
    logic   s1_valid_reg;
    stage_t s1_reg, s1_next;

    // Result register
    logic       out_valid_reg;
    logic [7:0] out_rdata_reg;
    logic [7:0] out_tbyte_reg;
    stage_t     out_reg;

    logic       advance;
    logic       take;
    logic [TX_PW-1:0] tx_wp_inc, tx_rp_inc;
    logic [RX_PW-1:0] rx_wp_inc, rx_rp_inc;
    logic       tx_empty, tx_full, rx_empty, rx_full;
    logic       tx_we, rx_we;
    logic [7:0] tx_dout, rx_dout;
    logic [CW-1:0] wp_c, rp_c, used_c, free_c;

    assign advance   = !out_valid_reg || rsp.ready;
    assign cmd.ready = !s1_valid_reg || advance;
    assign take      = cmd.valid && cmd.ready;

    // Slot after each pointer, wrapping at the ring's depth
    assign tx_wp_inc = (tx_wp_reg == TX_LAST) ? '0 : tx_wp_reg + 1'b1;
    assign tx_rp_inc = (tx_rp_reg == TX_LAST) ? '0 : tx_rp_reg + 1'b1;
    assign rx_wp_inc = (rx_wp_reg == RX_LAST) ? '0 : rx_wp_reg + 1'b1;
    assign rx_rp_inc = (rx_rp_reg == RX_LAST) ? '0 : rx_rp_reg + 1'b1;

    // One slot stays empty: full when the next write slot is the read slot
    assign tx_empty = (tx_rp_reg == tx_wp_reg);
    assign tx_full  = (tx_wp_inc == tx_rp_reg);
    assign rx_empty = (rx_rp_reg == rx_wp_reg);
    assign rx_full  = (rx_wp_inc == rx_rp_reg);

    assign tx_we = take && (cmd.kind == KIND_HOST_WRITE) && !tx_full;
    assign rx_we = take && (cmd.kind == KIND_LINK_BYTE) && !rx_full;

    always_comb
    begin
        tx_wp_next  = tx_wp_reg;
        tx_rp_next  = tx_rp_reg;
        rx_wp_next  = rx_wp_reg;
        rx_rp_next  = rx_rp_reg;
        driver_next = driver_reg;
        s1_next.read_valid = 1'b0;
        s1_next.tx_valid   = 1'b0;
        s1_next.accepted   = 1'b0;
        if (take)
        begin
            case (cmd.kind)
                KIND_HOST_WRITE:
                begin
                    // Driver goes on even when the byte is refused
                    driver_next = 1'b1;
                    if (!tx_full)
                    begin
                        tx_wp_next       = tx_wp_inc;
                        s1_next.accepted = 1'b1;
                    end
                end
                KIND_HOST_READ:
                begin
                    if (!rx_empty)
                    begin
                        rx_rp_next         = rx_rp_inc;
                        s1_next.read_valid = 1'b1;
                    end
                end
                KIND_LINK_BYTE:
                begin
                    if (!rx_full)
                    begin
                        rx_wp_next       = rx_wp_inc;
                        s1_next.accepted = 1'b1;
                    end
                end
                KIND_TX_TICK:
                begin
                    if (tx_empty)
                    begin
                        driver_next = 1'b0;
                    end
                    else if (cmd.link_ready)
                    begin
                        tx_rp_next       = tx_rp_inc;
                        s1_next.tx_valid = 1'b1;
                    end
                end
                KIND_RX_FLUSH:
                begin
                    rx_rp_next = rx_wp_reg;
                end
                default:
                begin
                    // Unused codes change nothing
                end
            endcase
        end
        // Free receive slots after this command: depth - 1 - bytes held
        wp_c   = CW'(rx_wp_next);
        rp_c   = CW'(rx_rp_next);
        used_c = (wp_c >= rp_c) ? wp_c - rp_c : RX_DEPTH_C - (rp_c - wp_c);
        free_c = RX_DEPTH_C - CW'(1) - used_c;
        s1_next.driver_on = driver_next;
        s1_next.rx_free   = free_c[FREE_W-1:0];
    end

    // Rings: read on every accepted command so the data lines up with the stage
    srtrb_ram #(.WIDTH(8), .DEPTH(TX_DEPTH)) u_tx_ram (
        .clk   (clk),
        .we    (tx_we),
        .waddr (tx_wp_reg),
        .wdata (cmd.data),
        .re    (take),
        .raddr (tx_rp_reg),
        .rdata (tx_dout)
    );

    srtrb_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
        .clk   (clk),
        .we    (rx_we),
        .waddr (rx_wp_reg),
        .wdata (cmd.data),
        .re    (take),
        .raddr (rx_rp_reg),
        .rdata (rx_dout)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_wp_reg     <= '0;
            tx_rp_reg     <= '0;
            rx_wp_reg     <= '0;
            rx_rp_reg     <= '0;
            driver_reg    <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            tx_wp_reg  <= tx_wp_next;
            tx_rp_reg  <= tx_rp_next;
            rx_wp_reg  <= rx_wp_next;
            rx_rp_reg  <= rx_rp_next;
            driver_reg <= driver_next;
            if (cmd.ready)
            begin
                s1_valid_reg <= take;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Payload: hold the stage while the result register is stalled
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_reg <= s1_next;
        end
        if (advance && s1_valid_reg)
        begin
            out_reg       <= s1_reg;
            out_rdata_reg <= s1_reg.read_valid ? rx_dout : 8'd0;
            out_tbyte_reg <= s1_reg.tx_valid ? tx_dout : 8'd0;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_data  = out_rdata_reg;
    assign rsp.read_valid = out_reg.read_valid;
    assign rsp.tx_byte    = out_tbyte_reg;
    assign rsp.tx_valid   = out_reg.tx_valid;
    assign rsp.accepted   = out_reg.accepted;
    assign rsp.driver_on  = out_reg.driver_on;
    assign rsp.rx_free    = out_reg.rx_free;

    // A stalled stage must not be lost while the result register is blocked
    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg)
        else $error("stage item dropped while response stalled");

    // A host write always leaves the driver on
    a_write_driver: assert property (@(posedge clk) disable iff (!rst_n)
        take && cmd.kind == KIND_HOST_WRITE |=> driver_reg)
        else $error("driver not enabled after host write");

    // A response never reports two different operations
    a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !((rsp.read_valid && rsp.tx_valid) ||
                        (rsp.read_valid && rsp.accepted) ||
                        (rsp.tx_valid && rsp.accepted)))
        else $error("response flags more than one operation");

    // A flush empties the receive ring
    a_flush_empty: assert property (@(posedge clk) disable iff (!rst_n)
        take && cmd.kind == KIND_RX_FLUSH |=> rx_rp_reg == rx_wp_reg)
        else $error("receive ring not empty after flush");

endmodule

>>> design/srtrb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module srtrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> verif/serial_rx_tx_ring_buffers_tb.sv
// Testbench: self-checking stimulus, prediction and response checks for the serial ring buffers.
`timescale 1ns / 1ps

module serial_rx_tx_ring_buffers_tb
    import srtrb_pkg::*;
();

    localparam int RX_SLOTS       = 64;
    localparam int TX_SLOTS       = 64;
    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 4;
    localparam int RANDOM_ITEMS   = 2000;
    localparam int PHASE_ITEMS    = 200;
    localparam int HOLD_OFF_AT    = 850;
    localparam int HOLD_OFF_LEN   = 300;
    localparam int DRAIN_CYCLES   = 16;
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int MAX_BURST      = 80;

    // Kind values the block leaves unused; they must still pass through untouched.
    localparam logic [2:0] KIND_SPARE_LO  = 3'd5;
    localparam logic [2:0] KIND_SPARE_MID = 3'd6;
    localparam logic [2:0] KIND_SPARE_HI  = 3'd7;

    // Idle percentages per traffic phase: none, sender gaps, receiver stalls, both.
    localparam int SEND_GAP_PCT[4]   = '{0, 50, 0, 28};
    localparam int RECV_STALL_PCT[4] = '{0, 0, 50, 28};

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic       link_ready;
    } cmd_t;

    typedef struct packed {
        logic [7:0]        read_data;
        logic              read_valid;
        logic [7:0]        tx_byte;
        logic              tx_valid;
        logic              accepted;
        logic              driver_on;
        logic [FREE_W-1:0] rx_free;
    } rsp_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    srtrb_in_if  cmd_if ();
    srtrb_out_if rsp_if ();

    serial_rx_tx_ring_buffers #(
        .RX_DEPTH (RX_SLOTS),
        .TX_DEPTH (TX_SLOTS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if.sink),
        .rsp   (rsp_if.source)
    );

    // Clock: high half, then low half.
    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    // Driven values live in registers with known initial values, so the block
    // never sees an unknown input, not even before the first clock edge.
    logic cmd_valid_q = 1'b0;
    cmd_t on_offer    = '0;
    logic rsp_ready_q = 1'b0;
    logic hold_off    = 1'b0;

    assign cmd_if.valid      = cmd_valid_q;
    assign cmd_if.kind       = on_offer.kind;
    assign cmd_if.data       = on_offer.data;
    assign cmd_if.link_ready = on_offer.link_ready;
    assign rsp_if.ready      = rsp_ready_q;

    cmd_t pending_items[$];
    rsp_t due_responses[$];
    int   sent_count     = 0;
    int   received_count = 0;
    int   mismatches     = 0;

    // Shadow copy of both rings and the driver enable.
    logic [7:0] tx_ring[TX_SLOTS];
    logic [7:0] rx_ring[RX_SLOTS];
    int         tx_head = 0;
    int         tx_tail = 0;
    int         rx_head = 0;
    int         rx_tail = 0;
    logic       line_driver = 1'b0;

    // Advance the shadow rings by one command and return the response it must give.
    // Heads are write positions, tails read positions; one slot always stays empty.
    function automatic rsp_t step_rings(cmd_t c);
        rsp_t r;
        int   nxt;
        int   held;
        r = '0;
        case (c.kind)
            KIND_HOST_WRITE:
            begin
                nxt = (tx_head + 1) % TX_SLOTS;
                if (nxt != tx_tail)
                begin
                    tx_ring[tx_head] = c.data;
                    tx_head          = nxt;
                    r.accepted       = 1'b1;
                end
                // A refused write still switches the driver on.
                line_driver = 1'b1;
            end
            KIND_HOST_READ:
            begin
                if (rx_tail != rx_head)
                begin
                    r.read_data  = rx_ring[rx_tail];
                    r.read_valid = 1'b1;
                    rx_tail      = (rx_tail + 1) % RX_SLOTS;
                end
            end
            KIND_LINK_BYTE:
            begin
                nxt = (rx_head + 1) % RX_SLOTS;
                if (nxt != rx_tail)
                begin
                    rx_ring[rx_head] = c.data;
                    rx_head          = nxt;
                    r.accepted       = 1'b1;
                end
            end
            KIND_TX_TICK:
            begin
                // Empty ring: switch the driver off. Data but link busy: do nothing.
                if (tx_tail == tx_head)
                    line_driver = 1'b0;
                else if (c.link_ready)
                begin
                    r.tx_byte  = tx_ring[tx_tail];
                    r.tx_valid = 1'b1;
                    tx_tail    = (tx_tail + 1) % TX_SLOTS;
                end
            end
            KIND_RX_FLUSH:
                rx_tail = rx_head;
            default:
                ;
        endcase
        held        = (rx_head + RX_SLOTS - rx_tail) % RX_SLOTS;
        r.driver_on = line_driver;
        r.rx_free   = FREE_W'(RX_SLOTS - 1 - held);
        return r;
    endfunction

    task automatic add_item(input logic [2:0] kind, input logic [7:0] data, input logic lr);
        pending_items.push_back('{kind: kind, data: data, link_ready: lr});
    endtask

    task automatic report_field(input string field, input logic [7:0] want_v,
                                input logic [7:0] got_v);
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want_v, got_v);
        mismatches++;
    endtask

    // Driver: hold the offered transaction until it is taken, then predict its
    // response and offer the next pending item, or, at random outside the hold-off, idle.
    always @(posedge clk or negedge rst_n)
    begin : driver
        int gap_pct;
        if (!rst_n)
        begin
            cmd_valid_q <= 1'b0;
            on_offer    <= '0;
        end
        else
        begin
            gap_pct = SEND_GAP_PCT[(sent_count / PHASE_ITEMS) % 4];
            if (cmd_if.valid && cmd_if.ready)
            begin
                due_responses.push_back(step_rings(on_offer));
                sent_count++;
            end
            if (cmd_if.valid && !cmd_if.ready)
            begin
                // Hold: the offer stays unchanged until the block takes it.
            end
            else if (pending_items.size() != 0
                     && (hold_off || $urandom_range(0, 99) >= gap_pct))
            begin
                cmd_valid_q <= 1'b1;
                on_offer    <= pending_items.pop_front();
            end
            else
                cmd_valid_q <= 1'b0;
        end
    end

    // Monitor: check each response taken against the oldest prediction, then
    // choose whether to stall the next cycle.
    always @(posedge clk or negedge rst_n)
    begin : monitor
        rsp_t seen;
        rsp_t want;
        int   stall_pct;
        if (!rst_n)
            rsp_ready_q <= 1'b0;
        else
        begin
            stall_pct = RECV_STALL_PCT[(received_count / PHASE_ITEMS) % 4];
            if (rsp_if.valid && rsp_if.ready)
            begin
                received_count++;
                seen = '{read_data: rsp_if.read_data, read_valid: rsp_if.read_valid,
                         tx_byte: rsp_if.tx_byte, tx_valid: rsp_if.tx_valid,
                         accepted: rsp_if.accepted, driver_on: rsp_if.driver_on,
                         rx_free: rsp_if.rx_free};
                if (due_responses.size() == 0)
                begin
                    $display("%0t: unexpected response, expected none, got %h", $time, seen);
                    mismatches++;
                end
                else
                begin
                    want = due_responses.pop_front();
                    if (seen.read_data !== want.read_data)
                        report_field("read_data", want.read_data, seen.read_data);
                    if (seen.read_valid !== want.read_valid)
                        report_field("read_valid", 8'(want.read_valid),
                                     8'(seen.read_valid));
                    if (seen.tx_byte !== want.tx_byte)
                        report_field("tx_byte", want.tx_byte, seen.tx_byte);
                    if (seen.tx_valid !== want.tx_valid)
                        report_field("tx_valid", 8'(want.tx_valid), 8'(seen.tx_valid));
                    if (seen.accepted !== want.accepted)
                        report_field("accepted", 8'(want.accepted), 8'(seen.accepted));
                    if (seen.driver_on !== want.driver_on)
                        report_field("driver_on", 8'(want.driver_on), 8'(seen.driver_on));
                    if (seen.rx_free !== want.rx_free)
                        report_field("rx_free", 8'(want.rx_free), 8'(seen.rx_free));
                end
            end
            rsp_ready_q <= !hold_off && ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Back-pressure: once traffic is flowing freely, refuse responses for a long
    // stretch while the sender keeps offering, so the block fills and drops cmd.ready.
    initial
    begin : back_pressure
        wait (sent_count >= HOLD_OFF_AT);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_OFF_LEN) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Safety net against a hung handshake.
    initial
    begin : watchdog
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("serial_rx_tx_ring_buffers_tb NOT OK");
        $finish;
    end

    initial
    begin : run
        int directed_count;
        int burst;
        int pick;

        // Directed: empty-ring corner cases, field extremes and unused kinds.
        add_item(KIND_TX_TICK, 8'h00, 1'b1);     // tick on empty ring, driver stays off
        add_item(KIND_HOST_READ, 8'hFF, 1'b0);   // read from empty receive ring
        add_item(KIND_RX_FLUSH, 8'h00, 1'b1);    // flush of an empty ring
        add_item(KIND_HOST_WRITE, 8'h00, 1'b0);
        add_item(KIND_HOST_WRITE, 8'hFF, 1'b1);
        add_item(KIND_TX_TICK, 8'h00, 1'b0);     // data waiting but link busy
        add_item(KIND_TX_TICK, 8'hFF, 1'b1);
        add_item(KIND_TX_TICK, 8'h00, 1'b1);
        add_item(KIND_TX_TICK, 8'h00, 1'b1);     // ring drained: driver off
        add_item(KIND_LINK_BYTE, 8'h00, 1'b0);
        add_item(KIND_LINK_BYTE, 8'hFF, 1'b1);
        add_item(KIND_LINK_BYTE, 8'h80, 1'b0);
        add_item(KIND_HOST_READ, 8'h00, 1'b0);
        add_item(KIND_RX_FLUSH, 8'hFF, 1'b0);    // drop the two bytes left
        add_item(KIND_HOST_READ, 8'h00, 1'b1);   // empty again after the flush
        add_item(KIND_SPARE_LO, 8'hFF, 1'b1);
        add_item(KIND_SPARE_MID, 8'h00, 1'b0);
        add_item(KIND_SPARE_HI, 8'h55, 1'b1);
        add_item(KIND_LINK_BYTE, 8'h01, 1'b1);
        add_item(KIND_HOST_READ, 8'h00, 1'b0);
        add_item(KIND_HOST_WRITE, 8'h7F, 1'b0);
        add_item(KIND_TX_TICK, 8'h00, 1'b1);
        add_item(KIND_TX_TICK, 8'h00, 1'b0);     // empty ring: driver off even with link busy
        directed_count = pending_items.size();

        // Random: bursts long enough to run either ring full and empty again, so
        // refused writes and dropped link bytes come up often; a little noise besides.
        while (pending_items.size() < directed_count + RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, MAX_BURST);
            pick  = $urandom_range(0, 9);
            case (pick)
                0, 1:
                    repeat (burst) add_item(KIND_HOST_WRITE, 8'($urandom_range(0, 255)),
                                            1'($urandom_range(0, 1)));
                2, 3:
                    repeat (burst) add_item(KIND_TX_TICK, 8'($urandom_range(0, 255)),
                                            $urandom_range(0, 3) != 0);
                4, 5:
                    repeat (burst) add_item(KIND_LINK_BYTE, 8'($urandom_range(0, 255)),
                                            1'($urandom_range(0, 1)));
                6, 7:
                    repeat (burst) add_item(KIND_HOST_READ, 8'($urandom_range(0, 255)),
                                            1'($urandom_range(0, 1)));
                8:
                    add_item(KIND_RX_FLUSH, 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)));
                default:
                    repeat ($urandom_range(1, 6))
                        add_item(3'($urandom_range(KIND_HOST_WRITE, KIND_SPARE_HI)),
                                 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            endcase
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: every command taken, every response back, then a few quiet cycles
        // to catch any stray response.
        wait (pending_items.size() == 0 && cmd_valid_q == 1'b0);
        wait (due_responses.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("serial_rx_tx_ring_buffers_tb OK");
        else
            $display("serial_rx_tx_ring_buffers_tb NOT OK");
        $finish;
    end

endmodule
